// ===== hdl/r2p_pkg.sv =====
// r2p_pkg: shared widths, constants and the per-cell data slice of the converter
// used by every module of the rectangular-to-polar pipeline; no dependencies
package r2p_pkg;

  localparam int IN_W       = 16;
  localparam int GUARD_BITS = 8;
  // working x/y: input times 256 grows by the cordic gain and sqrt(2)
  localparam int XW         = 27;
  // angle in radians times 2^24, pi plus the sum of all table entries
  localparam int ZW         = 28;
  localparam int MAX_STAGES = 24;
  localparam int GAIN_W     = 24;
  localparam int PROD_W     = (XW - 1) + GAIN_W;
  localparam int MAG_W      = 16;
  localparam int PH_W       = 16;
  localparam int PH_SHIFT   = 11;

  localparam logic signed [ZW-1:0] PI_ANGLE    = ZW'(52707179);
  localparam logic [GAIN_W-1:0]    INV_GAIN    = GAIN_W'(10188014);
  localparam logic signed [PH_W-1:0] PHASE_LIMIT = PH_W'(25736);

  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic                 last;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } r2p_slice_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = ZW'(13176795);
      1:  v = ZW'(7778716);
      2:  v = ZW'(4110060);
      3:  v = ZW'(2086331);
      4:  v = ZW'(1047214);
      5:  v = ZW'(524117);
      6:  v = ZW'(262123);
      7:  v = ZW'(131069);
      8:  v = ZW'(65536);
      9:  v = ZW'(32768);
      10: v = ZW'(16384);
      11: v = ZW'(8192);
      12: v = ZW'(4096);
      13: v = ZW'(2048);
      14: v = ZW'(1024);
      15: v = ZW'(512);
      16: v = ZW'(256);
      17: v = ZW'(128);
      18: v = ZW'(64);
      19: v = ZW'(32);
      20: v = ZW'(16);
      21: v = ZW'(8);
      22: v = ZW'(4);
      23: v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/r2p_prep.sv =====
// r2p_prep: scales the sample and turns the left half plane by +/-pi
// depends on r2p_pkg
module r2p_prep (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [r2p_pkg::IN_W-1:0]       in_re,
  input  logic signed [r2p_pkg::IN_W-1:0]       in_im,
  input  logic                                  in_last,
  output r2p_pkg::r2p_slice_t                   slice_out
);
  import r2p_pkg::*;

  logic signed [XW-1:0] x_scaled;
  logic signed [XW-1:0] y_scaled;
  r2p_slice_t           slice_nxt;
  r2p_slice_t           slice_r;

  assign x_scaled = {{(XW-IN_W-GUARD_BITS){in_re[IN_W-1]}}, in_re, {GUARD_BITS{1'b0}}};
  assign y_scaled = {{(XW-IN_W-GUARD_BITS){in_im[IN_W-1]}}, in_im, {GUARD_BITS{1'b0}}};

  always_comb begin
    slice_nxt      = '0;
    slice_nxt.vld  = in_valid;
    slice_nxt.last = in_last;
    slice_nxt.zero = (in_re == '0) && (in_im == '0);
    if (in_re[IN_W-1]) begin
      slice_nxt.x = -x_scaled;
      slice_nxt.y = -y_scaled;
      slice_nxt.z = in_im[IN_W-1] ? -PI_ANGLE : PI_ANGLE;
    end else begin
      slice_nxt.x = x_scaled;
      slice_nxt.y = y_scaled;
      slice_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= '0;
    end else if (en) begin
      slice_r <= slice_nxt;
    end
  end

  assign slice_out = slice_r;

endmodule

// ===== hdl/r2p_cell.sv =====
// r2p_cell: one vectoring micro-rotation with its output register
// depends on r2p_pkg
module r2p_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  r2p_pkg::r2p_slice_t slice_in,
  output r2p_pkg::r2p_slice_t slice_out
);
  import r2p_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_entry(STAGE);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  r2p_slice_t           slice_nxt;
  r2p_slice_t           slice_r;

  assign dx = slice_in.y >>> STAGE;
  assign dy = slice_in.x >>> STAGE;

  always_comb begin
    slice_nxt = slice_in;
    // rotate toward the x axis, direction from the sign of y
    if (!slice_in.y[XW-1]) begin
      slice_nxt.x = slice_in.x + dx;
      slice_nxt.y = slice_in.y - dy;
      slice_nxt.z = slice_in.z + ANGLE;
    end else begin
      slice_nxt.x = slice_in.x - dx;
      slice_nxt.y = slice_in.y + dy;
      slice_nxt.z = slice_in.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= '0;
    end else if (en) begin
      slice_r <= slice_nxt;
    end
  end

  assign slice_out = slice_r;

endmodule

// ===== hdl/r2p_post.sv =====
// r2p_post: gain correction multiply, rounding and clamping of both results
// depends on r2p_pkg; holds the output register of the result channel
module r2p_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  r2p_pkg::r2p_slice_t           slice_in,
  output logic                          out_vld,
  output logic [r2p_pkg::MAG_W-1:0]     out_mag,
  output logic signed [r2p_pkg::PH_W-1:0] out_phase,
  output logic                          out_lst
);
  import r2p_pkg::*;

  localparam int PH_FULL_W = ZW + 1 - PH_SHIFT;

  logic [XW-2:0]               x_pos;
  logic [PROD_W-1:0]           prod_nxt;
  logic signed [ZW:0]          z_bias;
  logic signed [PH_FULL_W-1:0] ph_full;
  logic signed [PH_W-1:0]      ph_nxt;

  logic                        vld_a_r;
  logic                        zero_a_r;
  logic                        last_a_r;
  logic [PROD_W-1:0]           prod_r;
  logic signed [PH_W-1:0]      ph_a_r;

  logic [PROD_W:0]             mag_sum;
  logic [PROD_W-32:0]          mag_full;
  logic [MAG_W-1:0]            mag_nxt;

  logic                        vld_r;
  logic                        last_r;
  logic [MAG_W-1:0]            mag_r;
  logic signed [PH_W-1:0]      ph_r;

  // x below zero counts as zero magnitude
  assign x_pos    = slice_in.x[XW-1] ? '0 : slice_in.x[XW-2:0];
  assign prod_nxt = PROD_W'(x_pos) * PROD_W'(INV_GAIN);

  assign z_bias  = {slice_in.z[ZW-1], slice_in.z} + (ZW+1)'(1024);
  assign ph_full = PH_FULL_W'(z_bias >>> PH_SHIFT);

  always_comb begin
    if (ph_full > PH_FULL_W'(PHASE_LIMIT)) begin
      ph_nxt = PHASE_LIMIT;
    end else if (ph_full < -PH_FULL_W'(PHASE_LIMIT)) begin
      ph_nxt = -PHASE_LIMIT;
    end else begin
      ph_nxt = ph_full[PH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      vld_a_r <= slice_in.vld;
      vld_r   <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_a_r <= slice_in.zero;
      last_a_r <= slice_in.last;
      prod_r   <= prod_nxt;
      ph_a_r   <= slice_in.zero ? '0 : ph_nxt;
    end
  end

  assign mag_sum  = {1'b0, prod_r} + (PROD_W+1)'(64'h8000_0000);
  assign mag_full = mag_sum[PROD_W:32];

  always_comb begin
    if (zero_a_r) begin
      mag_nxt = '0;
    end else if (mag_full > (PROD_W-31)'(16'hFFFF)) begin
      mag_nxt = '1;
    end else begin
      mag_nxt = mag_full[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= last_a_r;
      mag_r  <= mag_nxt;
      ph_r   <= ph_a_r;
    end
  end

  assign out_vld   = vld_r;
  assign out_mag   = mag_r;
  assign out_phase = ph_r;
  assign out_lst   = last_r;

endmodule

// ===== hdl/rect_to_polar_converter.sv =====
// rect_to_polar_converter: top level, cordic vectoring pipeline from complex sample to polar
// depends on r2p_pkg, r2p_prep, r2p_cell and r2p_post
//
// Converts one signed 16-bit complex sample per clock into its magnitude (gain
// corrected, rounded, 16-bit unsigned) and its four-quadrant phase atan2(im, re)
// in radians, signed Q2.13 within +/-25736; an all-zero sample gives 0 and 0,
// and in_last travels alongside as out_last. The datapath is a row of
// min(CORDIC_STAGES, 24) rotation cells between a pre-rotation register and two
// post-processing registers, and a new sample can enter on every clock while the
// row is not held. The whole row advances together: it holds its contents while
// a result waits at the output with out_ready low, and in that case in_ready is
// low as well.
module rect_to_polar_converter #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [r2p_pkg::IN_W-1:0]    in_real_part,
  input  logic signed [r2p_pkg::IN_W-1:0]    in_imag_part,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [r2p_pkg::MAG_W-1:0]          out_magnitude_out,
  output logic signed [r2p_pkg::PH_W-1:0]    out_phase_angle,
  output logic                               out_last
);
  import r2p_pkg::*;

  localparam int NUM_CELLS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic       advance;
  r2p_slice_t chain [NUM_CELLS+1];

  // the pipeline moves whenever the output register is free or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  r2p_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (in_valid),
    .in_re     (in_real_part),
    .in_im     (in_imag_part),
    .in_last   (in_last),
    .slice_out (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    r2p_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .slice_in  (chain[i]),
      .slice_out (chain[i+1])
    );
  end

  r2p_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .slice_in  (chain[NUM_CELLS]),
    .out_vld   (out_valid),
    .out_mag   (out_magnitude_out),
    .out_phase (out_phase_angle),
    .out_lst   (out_last)
  );

endmodule

// ===== dv/rect_to_polar_converter_tb.sv =====
`timescale 1ns / 1ps
// rect_to_polar_converter_tb: self-checking bench for the cordic rectangular-to-polar converter
// uses r2p_pkg for port widths and an in-bench bit-exact polar predictor; needs only the rtl

module rect_to_polar_converter_tb;

  localparam int STAGES     = 16;
  localparam int USED_STG   = (STAGES > 24) ? 24 : STAGES;
  localparam int LATENCY    = USED_STG + 3;
  localparam int MAX_SHOWN  = 10;

  // angle scale is radians times 2^24
  localparam longint ANG_PI    = 64'sd52707179;
  localparam longint GAIN_COMP = 64'sd10188014;
  localparam longint PH_CLAMP  = 64'sd25736;
  localparam longint ATAN_LUT [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic [r2p_pkg::MAG_W-1:0]        magnitude;
    logic signed [r2p_pkg::PH_W-1:0]  phase;
    logic                             last;
  } polar_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic signed [r2p_pkg::IN_W-1:0]  in_real_part = '0;
  logic signed [r2p_pkg::IN_W-1:0]  in_imag_part = '0;
  logic                             in_last = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [r2p_pkg::MAG_W-1:0]        out_magnitude_out;
  logic signed [r2p_pkg::PH_W-1:0]  out_phase_angle;
  logic                             out_last;

  polar_t pending_polar[$];
  int     mismatch_count = 0;
  int     src_gap_pct = 0;
  int     sink_stall_pct = 0;

  rect_to_polar_converter #(
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_real_part      (in_real_part),
    .in_imag_part      (in_imag_part),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_magnitude_out (out_magnitude_out),
    .out_phase_angle   (out_phase_angle),
    .out_last          (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("rect_to_polar_converter_tb failed");
    $finish;
  end

  function automatic polar_t predict_polar(input logic signed [15:0] re,
                                           input logic signed [15:0] im,
                                           input logic last);
    polar_t             res;
    longint             x;
    longint             y;
    longint             z;
    longint             dx;
    longint             dy;
    longint             ph;
    longint unsigned    mag;
    res.magnitude = '0;
    res.phase     = '0;
    res.last      = last;
    if (re != 0 || im != 0) begin
      x = longint'(re) * 256;
      y = longint'(im) * 256;
      z = 0;
      // left half plane: pre-rotate by pi, sign picked by the imaginary part
      if (x < 0) begin
        z = (im >= 0) ? ANG_PI : -ANG_PI;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < USED_STG; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_LUT[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_LUT[i];
        end
      end
      if (x < 0) x = 0;
      mag = longint'(unsigned'(x)) * longint'(unsigned'(GAIN_COMP));
      mag = (mag + (64'd1 << 31)) >> 32;
      if (mag > 64'd65535) mag = 64'd65535;
      ph = (z + 1024) >>> 11;
      if (ph > PH_CLAMP) ph = PH_CLAMP;
      if (ph < -PH_CLAMP) ph = -PH_CLAMP;
      res.magnitude = mag[15:0];
      res.phase     = ph[15:0];
    end
    return res;
  endfunction

  // receiver side: random backpressure per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : result_check
    polar_t got;
    polar_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_magnitude_out, out_phase_angle, out_last};
      if (pending_polar.size() == 0) begin
        if (mismatch_count < MAX_SHOWN)
          $display("unexpected transaction: mag=%0d phase=%0d last=%0b",
                   got.magnitude, got.phase, got.last);
        mismatch_count++;
      end else begin
        want = pending_polar.pop_front();
        if (got != want) begin
          if (mismatch_count < MAX_SHOWN)
            $display("mismatch: expected mag=%0d phase=%0d last=%0b, got mag=%0d phase=%0d last=%0b",
                     want.magnitude, want.phase, want.last,
                     got.magnitude, got.phase, got.last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic last);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_real_part <= re;
    in_imag_part <= im;
    in_last      <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_polar.push_back(predict_polar(re, im, last));
  endtask

  // zero sample, the four half-axes at full scale and unit samples on three half-axes
  task automatic test_zero_and_axes();
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sd32767, 16'sd0, 1'b0);
    send_sample(-16'sd32768, 16'sd0, 1'b1);
    send_sample(16'sd0, 16'sd32767, 1'b0);
    send_sample(16'sd0, -16'sd32768, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd1, 1'b1);
    send_sample(-16'sd1, 16'sd0, 1'b0);
  endtask

  // extreme corners in all four quadrants, largest magnitude, plus two unit diagonals
  task automatic test_corners();
    send_sample(16'sd32767, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b1);
    send_sample(-16'sd32768, -16'sd32768, 1'b0);
    send_sample(16'sd32767, -16'sd32768, 1'b1);
    send_sample(-16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0);
  endtask

  // left half plane samples on and near the negative real axis, where the phase rounds past pi
  task automatic test_near_pi();
    send_sample(-16'sd32768, 16'sd1, 1'b0);
    send_sample(-16'sd32768, -16'sd1, 1'b1);
    send_sample(-16'sd32767, 16'sd0, 1'b0);
    send_sample(-16'sd12345, -16'sd1, 1'b0);
    send_sample(-16'sd2, 16'sd1, 1'b1);
  endtask

  task automatic test_random_stream(input int count, input int src_pct, input int sink_pct);
    logic signed [15:0] re;
    logic signed [15:0] im;
    src_gap_pct    = src_pct;
    sink_stall_pct = sink_pct;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 5))
        0: begin
          re = 16'($urandom_range(0, 15)) - 16'sd8;
          im = 16'($urandom_range(0, 15)) - 16'sd8;
        end
        1: begin
          re = -16'($urandom_range(1, 32768));
          im = 16'($urandom_range(0, 6)) - 16'sd3;
        end
        2: begin
          re = ($urandom_range(0, 1) == 1) ? 16'sd0 : 16'($urandom);
          im = (re == 0) ? 16'($urandom) : 16'sd0;
        end
        default: begin
          re = 16'($urandom);
          im = 16'($urandom);
        end
      endcase
      send_sample(re, im, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_and_axes();
    test_corners();
    test_near_pi();
    test_random_stream(130, 17, 66);
    test_random_stream(130, 66, 17);
    test_random_stream(140, 0, 0);
    in_valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rect_to_polar_converter_tb passed");
    end else begin
      $display("rect_to_polar_converter_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/r2p_pkg.sv
hdl/r2p_prep.sv
hdl/r2p_cell.sv
hdl/r2p_post.sv
hdl/rect_to_polar_converter.sv
dv/rect_to_polar_converter_tb.sv
